@@ src/binco_pkg.sv @@
package binco_pkg;

   // field widths
   localparam int IDX_W  = 6;
   localparam int COEF_W = 30;
   // factor (n - i + 1) and divisor i of one step
   localparam int FAC_W  = 6;
   localparam int DIV_W  = 5;
   // running value times factor
   localparam int PROD_W = COEF_W + FAC_W;
   localparam int CNT_W  = $clog2(PROD_W);

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [COEF_W-1:0] coef_type;
   typedef logic [FAC_W-1:0]  fac_type;
   typedef logic [DIV_W-1:0]  div_type;
   typedef logic [PROD_W-1:0] prod_type;
   typedef logic [CNT_W-1:0]  cnt_type;

   // saturation / out-of-range code
   localparam coef_type COEF_MAX = '1;

   typedef enum logic [1:0] {
      CTRL_IDLE,
      CTRL_STEP,
      CTRL_DONE
   } ctrl_state_type;

   typedef enum logic [1:0] {
      STEP_IDLE,
      STEP_MUL,
      STEP_DIV
   } step_state_type;

endpackage

@@ src/binco_step.sv @@
// One multiplicative step: quotient = (value * factor) / divisor.
// Multiply: shift-add, one factor bit per cycle, MSB first.
// Divide: restoring, one quotient bit per cycle, narrow remainder.
module binco_step (
   input  logic                clock,
   input  logic                reset,
   input  logic                go,
   input  binco_pkg::coef_type value,
   input  binco_pkg::fac_type  factor,
   input  binco_pkg::div_type  divisor,
   output logic                done,
   output binco_pkg::prod_type quotient
);

   localparam binco_pkg::cnt_type MUL_LAST = binco_pkg::cnt_type'(binco_pkg::FAC_W - 1);
   localparam binco_pkg::cnt_type DIV_LAST = binco_pkg::cnt_type'(binco_pkg::PROD_W - 1);

   binco_pkg::step_state_type state_ff, state_in;
   binco_pkg::cnt_type        cnt_ff, cnt_in;
   binco_pkg::coef_type       val_ff;
   binco_pkg::fac_type        fac_ff, fac_in;
   binco_pkg::div_type        div_ff;
   binco_pkg::div_type        rem_ff, rem_in;
   binco_pkg::prod_type       prod_ff, prod_in;
   logic [binco_pkg::DIV_W:0] trial;
   logic                      qbit;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         binco_pkg::STEP_IDLE: begin
            if (go) state_in = binco_pkg::STEP_MUL;
         end
         binco_pkg::STEP_MUL: begin
            if (cnt_ff == MUL_LAST) state_in = binco_pkg::STEP_DIV;
         end
         binco_pkg::STEP_DIV: begin
            if (cnt_ff == DIV_LAST) begin
               state_in = go ? binco_pkg::STEP_MUL : binco_pkg::STEP_IDLE;
            end
         end
         default: state_in = binco_pkg::STEP_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      done     = (state_ff == binco_pkg::STEP_DIV) && (cnt_ff == DIV_LAST);
      quotient = {prod_ff[binco_pkg::PROD_W-2:0], qbit};
   end

   // trial subtract for the division
   assign trial = {rem_ff, prod_ff[binco_pkg::PROD_W-1]};
   assign qbit  = (trial >= {1'b0, div_ff});

   // datapath next values
   always_comb begin
      cnt_in  = cnt_ff;
      fac_in  = fac_ff;
      rem_in  = rem_ff;
      prod_in = prod_ff;
      case (state_ff)
         binco_pkg::STEP_MUL: begin
            prod_in = {prod_ff[binco_pkg::PROD_W-2:0], 1'b0}
                    + (fac_ff[binco_pkg::FAC_W-1]
                       ? binco_pkg::prod_type'(val_ff) : '0);
            fac_in  = {fac_ff[binco_pkg::FAC_W-2:0], 1'b0};
            cnt_in  = (cnt_ff == MUL_LAST) ? '0 : cnt_ff + 1'b1;
            rem_in  = '0;
         end
         binco_pkg::STEP_DIV: begin
            rem_in  = qbit ? binco_pkg::div_type'(trial - {1'b0, div_ff})
                           : binco_pkg::div_type'(trial);
            prod_in = quotient;
            cnt_in  = cnt_ff + 1'b1;
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= binco_pkg::STEP_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= go ? '0 : cnt_in;
      end
   end

   // payload registers, loaded on launch
   always_ff @(posedge clock) begin
      if (go) begin
         val_ff  <= value;
         fac_ff  <= factor;
         div_ff  <= divisor;
         prod_ff <= '0;
         rem_ff  <= '0;
      end else begin
         fac_ff  <= fac_in;
         prod_ff <= prod_in;
         rem_ff  <= rem_in;
      end
   end

endmodule

@@ src/binomial_coefficient.sv @@
// Binomial coefficient C(n,k) by the multiplicative rule.
//
// Request: drive req_n_value and req_k_value with start high; the transaction
// is taken at a rising edge where start is high and busy is low. busy stays
// high until the result has been shown.
// Response: rsp_coefficient is valid for exactly one cycle with rsp_valid
// high; the receiver cannot hold it off, and busy falls in the next cycle.
//
// Special cases (k > n, k = 0, k = n, and n above MAX_N) are answered in the
// cycle straight after the request edge. Otherwise the block runs min(k, n-k)
// steps through one shared step unit: a bit-serial multiply by (n-i+1), then
// a restoring division by i. A new request is taken only after the response.
// A value above 30 bits saturates to all ones and ends the run early.
// One transaction at a time; nothing is kept between transactions.
// Reset (synchronous, active high) returns the block to idle and drops any
// transaction in flight.
module binomial_coefficient #(
   parameter int MAX_N = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  binco_pkg::idx_type  req_n_value,
   input  binco_pkg::idx_type  req_k_value,
   output logic                rsp_valid,
   output binco_pkg::coef_type rsp_coefficient
);

   binco_pkg::ctrl_state_type state_ff, state_in;
   binco_pkg::idx_type        n_ff, n_in;
   binco_pkg::div_type        kk_ff, kk_in;
   binco_pkg::div_type        i_ff, i_in;
   binco_pkg::coef_type       result_ff, result_in;

   logic                      accept;
   logic                      special;
   binco_pkg::coef_type       special_val;
   binco_pkg::idx_type        n_minus_k;

   logic                      go;
   binco_pkg::coef_type       go_value;
   binco_pkg::fac_type        go_factor;
   binco_pkg::div_type        go_divisor;
   logic                      step_done;
   binco_pkg::prod_type       step_q;
   logic                      overflow;
   logic                      last_step;

   assign accept    = start && !busy;
   assign n_minus_k = req_n_value - req_k_value;

   // special cases decided straight from the request
   always_comb begin
      special     = 1'b1;
      special_val = '0;
      if (req_k_value > req_n_value) begin
         special_val = '0;
      end else if (req_k_value == '0 || req_k_value == req_n_value) begin
         special_val = binco_pkg::coef_type'(1);
      end else if (req_n_value > binco_pkg::idx_type'(MAX_N)) begin
         special_val = binco_pkg::COEF_MAX;
      end else begin
         special = 1'b0;
      end
   end

   assign overflow  = |step_q[binco_pkg::PROD_W-1:binco_pkg::COEF_W];
   assign last_step = (i_ff == kk_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         binco_pkg::CTRL_IDLE: begin
            if (accept) state_in = special ? binco_pkg::CTRL_DONE : binco_pkg::CTRL_STEP;
         end
         binco_pkg::CTRL_STEP: begin
            if (step_done && (overflow || last_step)) state_in = binco_pkg::CTRL_DONE;
         end
         binco_pkg::CTRL_DONE: state_in = binco_pkg::CTRL_IDLE;
         default:              state_in = binco_pkg::CTRL_IDLE;
      endcase
   end

   // outputs and step launch
   always_comb begin
      busy            = (state_ff != binco_pkg::CTRL_IDLE);
      rsp_valid       = (state_ff == binco_pkg::CTRL_DONE);
      rsp_coefficient = result_ff;
      go              = 1'b0;
      go_value        = binco_pkg::coef_type'(1);
      go_factor       = req_n_value;
      go_divisor      = binco_pkg::div_type'(1);
      case (state_ff)
         binco_pkg::CTRL_IDLE: begin
            go = accept && !special;
         end
         binco_pkg::CTRL_STEP: begin
            go         = step_done && !overflow && !last_step;
            go_value   = step_q[binco_pkg::COEF_W-1:0];
            go_factor  = n_ff - binco_pkg::idx_type'(i_ff);
            go_divisor = i_ff + 1'b1;
         end
         default: go = 1'b0;
      endcase
   end

   // working registers
   always_comb begin
      n_in      = n_ff;
      kk_in     = kk_ff;
      i_in      = i_ff;
      result_in = result_ff;
      case (state_ff)
         binco_pkg::CTRL_IDLE: begin
            n_in      = req_n_value;
            kk_in     = (n_minus_k < req_k_value) ? binco_pkg::div_type'(n_minus_k)
                                                  : binco_pkg::div_type'(req_k_value);
            i_in      = binco_pkg::div_type'(1);
            result_in = special_val;
         end
         binco_pkg::CTRL_STEP: begin
            if (step_done) begin
               i_in      = i_ff + 1'b1;
               result_in = overflow ? binco_pkg::COEF_MAX
                                    : step_q[binco_pkg::COEF_W-1:0];
            end
         end
         default: i_in = i_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= binco_pkg::CTRL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff      <= n_in;
      kk_ff     <= kk_in;
      i_ff      <= i_in;
      result_ff <= result_in;
   end

   // shared multiply/divide step
   binco_step u_step (
      .clock    (clock),
      .reset    (reset),
      .go       (go),
      .value    (go_value),
      .factor   (go_factor),
      .divisor  (go_divisor),
      .done     (step_done),
      .quotient (step_q)
   );

endmodule

@@ src/binco_checker.sv @@
// Port-level checks on the binomial coefficient block.
module binco_checker (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input binco_pkg::idx_type  req_n_value,
   input binco_pkg::idx_type  req_k_value,
   input logic                rsp_valid,
   input binco_pkg::coef_type rsp_coefficient
);

   // a response only ever closes a running transaction
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> busy)
      else $error("response while idle");

   // one response per transaction, then idle again
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid && !busy)
      else $error("response not a single pulse");

   // an accepted request makes the block busy
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("request accepted but not busy");

   // k above n answers zero at once
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_k_value > req_n_value))
      |=> (rsp_valid && (rsp_coefficient == '0)))
      else $error("k above n did not give zero");

   // k zero answers one at once
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_k_value == '0))
      |=> (rsp_valid && (rsp_coefficient == binco_pkg::coef_type'(1))))
      else $error("k zero did not give one");

endmodule

bind binomial_coefficient binco_checker u_binco_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_n_value     (req_n_value),
   .req_k_value     (req_k_value),
   .rsp_valid       (rsp_valid),
   .rsp_coefficient (rsp_coefficient)
);

@@ tb/sv/tb_binomial_coefficient.sv @@
module tb_binomial_coefficient;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_N          = 32;
   localparam int RANDOM_ITEMS   = 540;
   localparam int DRAIN_LIMIT    = 2000;
   localparam int SETTLE_CYCLES  = 20;
   localparam int REPORT_LIMIT   = 10;
   localparam bit FIXED          = 1'b1;
   localparam bit PREDICT        = 1'b0;

   // one directed transaction: indices, and the answer where it is obvious
   typedef struct packed {
      binco_pkg::idx_type  n;
      binco_pkg::idx_type  k;
      logic                fixed;
      binco_pkg::coef_type value;
   } probe_row_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   binco_pkg::idx_type  req_n_value;
   binco_pkg::idx_type  req_k_value;
   logic                rsp_valid;
   binco_pkg::coef_type rsp_coefficient;

   // answer source for the transaction currently offered
   logic                row_fixed;
   binco_pkg::coef_type row_value;
   logic                txn_taken;

   binco_pkg::coef_type pending_coefs [$];
   int unsigned         mismatch_count = 0;

   probe_row_type probe_rows [0:21] = '{
      '{6'd0,  6'd0,  FIXED,   30'd1},
      '{6'd0,  6'd63, FIXED,   30'd0},
      '{6'd63, 6'd63, FIXED,   30'd1},
      '{6'd63, 6'd0,  FIXED,   30'd1},
      '{6'd63, 6'd62, FIXED,   binco_pkg::COEF_MAX},
      '{6'd33, 6'd1,  FIXED,   binco_pkg::COEF_MAX},
      '{6'd40, 6'd20, FIXED,   binco_pkg::COEF_MAX},
      '{6'd62, 6'd63, FIXED,   30'd0},
      '{6'd32, 6'd0,  FIXED,   30'd1},
      '{6'd32, 6'd32, FIXED,   30'd1},
      '{6'd32, 6'd33, FIXED,   30'd0},
      '{6'd32, 6'd1,  FIXED,   30'd32},
      '{6'd32, 6'd31, FIXED,   30'd32},
      '{6'd32, 6'd16, FIXED,   30'd601080390},
      '{6'd20, 6'd10, FIXED,   30'd184756},
      '{6'd1,  6'd1,  FIXED,   30'd1},
      '{6'd2,  6'd1,  FIXED,   30'd2},
      '{6'd5,  6'd2,  PREDICT, 30'd0},
      '{6'd10, 6'd3,  PREDICT, 30'd0},
      '{6'd31, 6'd15, PREDICT, 30'd0},
      '{6'd32, 6'd15, PREDICT, 30'd0},
      '{6'd17, 6'd9,  PREDICT, 30'd0}
   };

   binomial_coefficient #(
      .MAX_N(MAX_N)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_n_value    (req_n_value),
      .req_k_value    (req_k_value),
      .rsp_valid      (rsp_valid),
      .rsp_coefficient(rsp_coefficient)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // C(n,k) by the multiplicative rule over the shorter side, with the
   // out-of-range and saturation codes
   function automatic binco_pkg::coef_type binomial_of(binco_pkg::idx_type n,
                                                       binco_pkg::idx_type k);
      logic [63:0] running;
      int unsigned steps;
      int unsigned nn;
      nn = n;
      if (k > n) return '0;
      if (k == 0 || k == n) return binco_pkg::coef_type'(1);
      if (nn > MAX_N) return binco_pkg::COEF_MAX;
      steps = (nn - k < k) ? nn - k : k;
      running = 64'd1;
      for (int unsigned i = 1; i <= steps; i++) begin
         running = running * (nn - i + 1) / i;
         if (running > binco_pkg::COEF_MAX) return binco_pkg::COEF_MAX;
      end
      return running[binco_pkg::COEF_W-1:0];
   endfunction

   // record accepted transactions and check each result against the oldest one
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         pending_coefs.push_back(row_fixed ? row_value
                                           : binomial_of(req_n_value, req_k_value));
      end
      txn_taken <= !reset && start && !busy;
      if (!reset && rsp_valid) begin
         if (pending_coefs.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("%0t: unexpected result, coefficient %0d", $realtime,
                        rsp_coefficient);
         end else begin
            binco_pkg::coef_type want;
            want = pending_coefs.pop_front();
            if (rsp_coefficient !== want) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: coefficient mismatch, expected %0d got %0d",
                           $realtime, want, rsp_coefficient);
            end
         end
      end
   end

   // offer one transaction and hold it until taken; start stays high
   task automatic issue_request(binco_pkg::idx_type n, binco_pkg::idx_type k,
                                logic fixed, binco_pkg::coef_type value);
      start       <= 1'b1;
      req_n_value <= n;
      req_k_value <= k;
      row_fixed   <= fixed;
      row_value   <= value;
      do @(negedge clock); while (!txn_taken);
   endtask

   // drop start for a while, with junk on the index ports
   task automatic idle_for(int unsigned cycles);
      if (cycles > 0) begin
         start       <= 1'b0;
         req_n_value <= binco_pkg::idx_type'($urandom);
         req_k_value <= binco_pkg::idx_type'($urandom);
         repeat (cycles) @(negedge clock);
      end
   endtask

   // mostly back to back, some short gaps, a few long ones
   function automatic int unsigned random_gap();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 90) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   // drop start and hold off until every outstanding result has come back, or the wait limit runs out
   task automatic drain_results();
      int unsigned waited;
      waited = 0;
      start <= 1'b0;
      while (pending_coefs.size() > 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
   endtask

   // stimulus
   initial begin
      binco_pkg::idx_type n;
      binco_pkg::idx_type k;
      int unsigned        pick;
      int unsigned        lost_count;

      reset          = 1'b1;
      start          = 1'b0;
      req_n_value    = '0;
      req_k_value    = '0;
      row_fixed      = PREDICT;
      row_value      = '0;
      lost_count     = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed corners
      foreach (probe_rows[r]) begin
         issue_request(probe_rows[r].n, probe_rows[r].k, probe_rows[r].fixed,
                       probe_rows[r].value);
         idle_for(random_gap());
      end
      drain_results();

      // random mix: mostly in-range pairs, then k above n, then n out of range, and a few fully random pairs
      for (int item = 0; item < RANDOM_ITEMS; item++) begin
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            n = binco_pkg::idx_type'($urandom_range(1, MAX_N));
            k = binco_pkg::idx_type'($urandom_range(0, n));
         end else if (pick < 85) begin
            n = binco_pkg::idx_type'($urandom_range(0, 62));
            k = binco_pkg::idx_type'($urandom_range(n + 1, 63));
         end else if (pick < 95) begin
            n = binco_pkg::idx_type'($urandom_range(MAX_N + 1, 63));
            k = binco_pkg::idx_type'($urandom);
         end else begin
            n = binco_pkg::idx_type'($urandom);
            k = binco_pkg::idx_type'($urandom);
         end
         issue_request(n, k, PREDICT, '0);
         if (item % 90 == 89)
            drain_results();
         else
            idle_for(random_gap());
      end

      // wind down
      drain_results();
      lost_count = pending_coefs.size();
      if (lost_count > 0)
         $display("%0t: %0d results never arrived", $realtime, lost_count);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && lost_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // watchdog
   initial begin
      #4_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
